>>> hw/rtl/mwo_pkg.sv
// Shared constants, types and fixed-point helpers for the mecanum odometry block.
package mwo_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int ANGLE_STEPS = 24;
  localparam int SUM_W       = COUNT_BITS + 2;
  localparam int CNT_W       = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
  localparam int CORD_W      = 36;
  localparam int MUL_W       = 64;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MUL_CNT_W   = $clog2(MUL_W);
  localparam int DIV_W       = 84;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int DVS_W       = 32;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_DPC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YG  = 8'd1;

  localparam logic [47:0] DPC_RST = 48'd561518091;
  localparam logic [31:0] YG_RST  = 32'd499879432;

  localparam logic [33:0] PI29_U     = 34'd1686629713;
  localparam logic [33:0] TWO_PI29_U = 34'd3373259426;
  localparam logic signed [33:0] PI29_S      = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI29_S = 34'sd843314857;
  localparam logic signed [CORD_W-1:0] CORDIC_K = 36'sd652032874;

  localparam logic signed [63:0] RATE_SCALE = 64'sd1000000;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef logic signed [63:0]       s64_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CORD_W-1:0] cord_t;

  // atan(2^-i) in Q2.30
  function automatic cord_t atan_q(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h3243F6A8;   5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;   5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;   5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;   5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;   5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({{(CORD_W-32){1'b0}}, v});
  endfunction

  // round half up, arithmetic shift right, saturate to 64 bits
  function automatic s64_t shr_sat(input prod_t w, input int unsigned sh);
    prod_t t;
    t = w + (prod_t'(1) <<< (sh - 1));
    t = t >>> sh;
    if (t[PROD_W-1:63] != {(PROD_W-63){t[63]}}) begin
      return t[PROD_W-1] ? S64_MIN : S64_MAX;
    end
    return $signed(t[63:0]);
  endfunction

  function automatic s64_t sat_add(input s64_t a, input s64_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return $signed(s[63:0]);
  endfunction

  // turn a quotient magnitude and sign into a saturated signed rate
  function automatic s64_t vel_post(input logic [DIV_W-1:0] q, input logic neg);
    logic [63:0] m;
    m = q[63:0];
    if (q[DIV_W-1:64] != '0) begin
      return neg ? S64_MIN : S64_MAX;
    end
    if (!neg) begin
      return m[63] ? S64_MAX : $signed(m);
    end
    if (m > {1'b1, 63'b0}) begin
      return S64_MIN;
    end
    return $signed(64'd0 - m);
  endfunction

endpackage

>>> hw/rtl/mwo_mul.sv
// Bit-serial signed 64x64 multiplier, one multiplier bit per cycle.
module mwo_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mwo_pkg::MUL_W-1:0]    mul_a,
  input  logic signed [mwo_pkg::MUL_W-1:0]    mul_b,
  output logic                                done,
  output logic signed [mwo_pkg::PROD_W-1:0]   prod
);
  import mwo_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  prod_t                mcand_r;
  prod_t                acc_r;
  logic [MUL_W-1:0]     mplier_r;
  prod_t                addend;
  prod_t                acc_nxt;
  logic                 last_bit;

  assign last_bit = (cnt_r == MUL_CNT_W'(MUL_W - 1));
  assign addend   = mplier_r[0] ? mcand_r : '0;
  // the sign bit of the multiplier carries negative weight
  assign acc_nxt  = last_bit ? (acc_r - addend) : (acc_r + addend);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_bit;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= {{(PROD_W-MUL_W){mul_a[MUL_W-1]}}, mul_a};
      mplier_r <= mul_b;
      acc_r    <= '0;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> hw/rtl/mwo_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module mwo_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mwo_pkg::DIV_W-1:0]    dividend,
  input  logic [mwo_pkg::DVS_W-1:0]    divisor,
  output logic                         done,
  output logic [mwo_pkg::DIV_W-1:0]    quot,
  output logic [mwo_pkg::DVS_W-1:0]    rem
);
  import mwo_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;
  logic                 last_bit;

  assign last_bit = (cnt_r == DIV_CNT_W'(DIV_W - 1));
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign ge       = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_bit;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

>>> hw/rtl/mecanum_wheel_odometry_top.sv
// Top level of the four-wheel mecanum odometry block with its sequencer.
// Items are taken one at a time: in_ready is high only while the sequencer
// is idle. A reading with elapsed_us zero skips the rate divisions, and an
// item with link_ok low is dropped. Per item, the bit-serial multiplier
// (eleven products, eight when elapsed_us is zero) and the bit-serial divider
// (four divisions, one when elapsed_us is zero) do most of the work.
// Reset (rst_n low, synchronous): pose and stored counts clear, registers take defaults.
module mecanum_wheel_odometry_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_link_ok,
  input  logic signed [31:0]                   in_count_one,
  input  logic signed [31:0]                   in_count_two,
  input  logic signed [31:0]                   in_count_three,
  input  logic signed [31:0]                   in_count_four,
  input  logic [31:0]                          in_elapsed_us,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [63:0]                   out_pos_x,
  output logic signed [63:0]                   out_pos_y,
  output logic signed [31:0]                   out_heading,
  output logic signed [63:0]                   out_vel_x,
  output logic signed [63:0]                   out_vel_y,
  output logic signed [63:0]                   out_yaw_rate,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mwo_pkg::*;

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DX   = 5'd1;
  localparam logic [4:0] ST_DY   = 5'd2;
  localparam logic [4:0] ST_DT   = 5'd3;
  localparam logic [4:0] ST_TH   = 5'd4;
  localparam logic [4:0] ST_CORD = 5'd5;
  localparam logic [4:0] ST_GX1  = 5'd6;
  localparam logic [4:0] ST_GX2  = 5'd7;
  localparam logic [4:0] ST_PX   = 5'd8;
  localparam logic [4:0] ST_GY1  = 5'd9;
  localparam logic [4:0] ST_GY2  = 5'd10;
  localparam logic [4:0] ST_PY   = 5'd11;
  localparam logic [4:0] ST_HEAD = 5'd12;
  localparam logic [4:0] ST_V0   = 5'd13;
  localparam logic [4:0] ST_V1   = 5'd14;
  localparam logic [4:0] ST_V2   = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  // phase within a state: launch, wait on multiplier, wait on divider
  localparam logic [1:0] PH_GO  = 2'd0;
  localparam logic [1:0] PH_MUL = 2'd1;
  localparam logic [1:0] PH_DIV = 2'd2;

  logic [4:0] state_r;
  logic [1:0] phase_r;

  // configuration and odometry state
  logic [47:0]           dpc_r;
  logic [31:0]           yg_r;
  logic [COUNT_BITS-1:0] last_r [4];
  s64_t                  pose_x_r;
  s64_t                  pose_y_r;
  logic signed [31:0]    head_r;

  // per-item working registers
  logic signed [SUM_W-1:0] sx_r, sy_r, st_r;
  logic [31:0]             us_r;
  s64_t                    dx_r, dy_r, dt_r, dth_r, dth29_r, g_r;
  s64_t                    vx_r, vy_r, vw_r;
  prod_t                   acc_r;
  cord_t                   cx_r, cy_r, cz_r;
  logic                    flip_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    vneg_r;

  // result register, parts the sequencer from the output side
  logic                    out_valid_r;
  s64_t                    o_px_r, o_py_r, o_vx_r, o_vy_r, o_vw_r;
  logic signed [31:0]      o_hd_r;
  logic                    out_load;

  // arithmetic units
  logic                  mul_start, mul_done;
  s64_t                  mul_a, mul_b;
  prod_t                 mul_prod;
  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_dividend, div_quot;
  logic [DVS_W-1:0]      div_divisor, div_rem;

  mwo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  mwo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // wheel order and sign: -two, -three, four, one; differences wrap at COUNT_BITS
  logic [COUNT_BITS-1:0]       cur [4];
  logic signed [COUNT_BITS-1:0] dif [4];
  logic signed [SUM_W-1:0]      de [4];

  always_comb begin
    cur[0] = COUNT_BITS'(0) - in_count_two[COUNT_BITS-1:0];
    cur[1] = COUNT_BITS'(0) - in_count_three[COUNT_BITS-1:0];
    cur[2] = in_count_four[COUNT_BITS-1:0];
    cur[3] = in_count_one[COUNT_BITS-1:0];
    for (int i = 0; i < 4; i++) begin
      dif[i] = $signed(cur[i] - last_r[i]);
      de[i]  = {{2{dif[i][COUNT_BITS-1]}}, dif[i]};
    end
  end

  // multiplier operand select
  logic signed [63:0] dpc_s, yg_s;
  assign dpc_s = $signed({16'b0, dpc_r});
  assign yg_s  = $signed({32'b0, yg_r});

  always_comb begin
    mul_a = dx_r;
    mul_b = RATE_SCALE;
    case (state_r)
      ST_DX:  begin mul_a = {{(64-SUM_W){sx_r[SUM_W-1]}}, sx_r}; mul_b = dpc_s; end
      ST_DY:  begin mul_a = {{(64-SUM_W){sy_r[SUM_W-1]}}, sy_r}; mul_b = dpc_s; end
      ST_DT:  begin mul_a = {{(64-SUM_W){st_r[SUM_W-1]}}, st_r}; mul_b = dpc_s; end
      ST_TH:  begin mul_a = dt_r; mul_b = yg_s; end
      ST_GX1: begin mul_a = dx_r; mul_b = {{(64-CORD_W){cx_r[CORD_W-1]}}, cx_r}; end
      ST_GX2: begin mul_a = dy_r; mul_b = {{(64-CORD_W){cy_r[CORD_W-1]}}, cy_r}; end
      ST_GY1: begin mul_a = dx_r; mul_b = {{(64-CORD_W){cy_r[CORD_W-1]}}, cy_r}; end
      ST_GY2: begin mul_a = dy_r; mul_b = {{(64-CORD_W){cx_r[CORD_W-1]}}, cx_r}; end
      ST_V0:  begin mul_a = dx_r;  mul_b = RATE_SCALE; end
      ST_V1:  begin mul_a = dy_r;  mul_b = RATE_SCALE; end
      ST_V2:  begin mul_a = dth_r; mul_b = RATE_SCALE; end
      default: begin mul_a = dx_r; mul_b = RATE_SCALE; end
    endcase
  end

  assign mul_start = (phase_r == PH_GO) &&
                     (state_r inside {ST_DX, ST_DY, ST_DT, ST_TH, ST_GX1, ST_GX2,
                                      ST_GY1, ST_GY2, ST_V0, ST_V1, ST_V2});

  // divider: heading step modulo two pi, or scaled step over elapsed time
  logic        is_vel;
  logic [63:0] th_mag;
  prod_t       prod_mag;

  assign is_vel   = (state_r inside {ST_V0, ST_V1, ST_V2});
  assign th_mag   = dth29_r[63] ? (64'd0 - dth29_r) : dth29_r;
  assign prod_mag = mul_prod[PROD_W-1] ? (prod_t'(0) - mul_prod) : mul_prod;

  always_comb begin
    if (is_vel) begin
      div_dividend = prod_mag[DIV_W-1:0];
      div_divisor  = us_r;
    end else begin
      div_dividend = {{(DIV_W-64){1'b0}}, th_mag};
      div_divisor  = TWO_PI29_U[DVS_W-1:0];
    end
  end

  assign div_start = ((state_r == ST_HEAD) && (phase_r == PH_GO)) ||
                     (is_vel && (phase_r == PH_MUL) && mul_done);

  // CORDIC fold of the old heading into [-pi/2, pi/2] and one rotation step
  logic signed [33:0] h34, hf;
  logic               fl;
  cord_t              xs, ys, at, x_n, y_n, z_n;

  always_comb begin
    h34 = {{2{head_r[31]}}, head_r};
    hf  = h34;
    fl  = 1'b0;
    if (h34 > HALF_PI29_S) begin
      hf = h34 - PI29_S;
      fl = 1'b1;
    end else if (h34 < -HALF_PI29_S) begin
      hf = h34 + PI29_S;
      fl = 1'b1;
    end
    xs = cx_r >>> cnt_r;
    ys = cy_r >>> cnt_r;
    at = atan_q(5'(cnt_r));
    if (!cz_r[CORD_W-1]) begin
      x_n = cx_r - ys;
      y_n = cy_r + xs;
      z_n = cz_r - at;
    end else begin
      x_n = cx_r + ys;
      y_n = cy_r - xs;
      z_n = cz_r + at;
    end
  end

  // heading update: add the step modulo two pi, keep in [-pi, pi)
  logic [33:0] m_step, h_base, h_acc, h_wrap, h_new;

  always_comb begin
    if (!dth29_r[63]) begin
      m_step = {2'b0, div_rem};
    end else if (div_rem != '0) begin
      m_step = TWO_PI29_U - {2'b0, div_rem};
    end else begin
      m_step = '0;
    end
    h_base = {{2{head_r[31]}}, head_r} + PI29_U;
    h_acc  = h_base + m_step;
    h_wrap = (h_acc >= TWO_PI29_U) ? (h_acc - TWO_PI29_U) : h_acc;
    h_new  = h_wrap - PI29_U;
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // sequencer and odometry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_GO;
      out_valid_r <= 1'b0;
      dpc_r       <= DPC_RST;
      yg_r        <= YG_RST;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      head_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        last_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_DPC) begin
          dpc_r <= cfg_data[47:0];
        end else if (cfg_index == CFG_YG) begin
          yg_r <= cfg_data[31:0];
        end
      end

      // drop the result once it has been transferred; a new load wins
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (mul_start) begin
        phase_r <= PH_MUL;
      end
      if (div_start) begin
        phase_r <= PH_DIV;
      end

      case (state_r)
        ST_IDLE: begin
          // an item with link_ok low is taken and dropped without effect
          if (in_valid && in_link_ok) begin
            for (int i = 0; i < 4; i++) begin
              last_r[i] <= cur[i];
            end
            sx_r    <= de[0] + de[1] + de[2] + de[3];
            sy_r    <= -de[0] + de[1] - de[2] + de[3];
            st_r    <= -de[0] - de[1] + de[2] + de[3];
            us_r    <= in_elapsed_us;
            state_r <= ST_DX;
            phase_r <= PH_GO;
          end
        end
        ST_DX: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            dx_r    <= shr_sat(mul_prod, 18);
            state_r <= ST_DY;
            phase_r <= PH_GO;
          end
        end
        ST_DY: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            dy_r    <= shr_sat(mul_prod, 18);
            state_r <= ST_DT;
            phase_r <= PH_GO;
          end
        end
        ST_DT: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            dt_r    <= shr_sat(mul_prod, 16);
            state_r <= ST_TH;
            phase_r <= PH_GO;
          end
        end
        ST_TH: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            dth_r   <= shr_sat(mul_prod, 30);
            dth29_r <= shr_sat(mul_prod, 33);
            // seed the rotation with the folded old heading
            cx_r    <= CORDIC_K;
            cy_r    <= '0;
            cz_r    <= {{(CORD_W-35){hf[33]}}, hf, 1'b0};
            flip_r  <= fl;
            cnt_r   <= '0;
            state_r <= ST_CORD;
            phase_r <= PH_GO;
          end
        end
        ST_CORD: begin
          if (cnt_r == CNT_W'(ANGLE_STEPS - 1)) begin
            cx_r    <= flip_r ? -x_n : x_n;
            cy_r    <= flip_r ? -y_n : y_n;
            state_r <= ST_GX1;
            phase_r <= PH_GO;
          end else begin
            cx_r  <= x_n;
            cy_r  <= y_n;
            cz_r  <= z_n;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_GX1: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            acc_r   <= mul_prod;
            state_r <= ST_GX2;
            phase_r <= PH_GO;
          end
        end
        ST_GX2: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            acc_r   <= acc_r - mul_prod;
            state_r <= ST_PX;
            phase_r <= PH_GO;
          end
        end
        ST_PX: begin
          if (phase_r == PH_GO) begin
            g_r     <= shr_sat(acc_r, 30);
            phase_r <= PH_MUL;
          end else begin
            pose_x_r <= sat_add(pose_x_r, g_r);
            state_r  <= ST_GY1;
            phase_r  <= PH_GO;
          end
        end
        ST_GY1: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            acc_r   <= mul_prod;
            state_r <= ST_GY2;
            phase_r <= PH_GO;
          end
        end
        ST_GY2: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            acc_r   <= acc_r + mul_prod;
            state_r <= ST_PY;
            phase_r <= PH_GO;
          end
        end
        ST_PY: begin
          if (phase_r == PH_GO) begin
            g_r     <= shr_sat(acc_r, 30);
            phase_r <= PH_MUL;
          end else begin
            pose_y_r <= sat_add(pose_y_r, g_r);
            state_r  <= ST_HEAD;
            phase_r  <= PH_GO;
          end
        end
        ST_HEAD: begin
          if ((phase_r == PH_DIV) && div_done) begin
            head_r  <= $signed(h_new[31:0]);
            phase_r <= PH_GO;
            // zero elapsed time: rates read zero, skip the divisions
            if (us_r == '0) begin
              vx_r    <= '0;
              vy_r    <= '0;
              vw_r    <= '0;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_V0;
            end
          end
        end
        ST_V0, ST_V1, ST_V2: begin
          if ((phase_r == PH_MUL) && mul_done) begin
            vneg_r <= mul_prod[PROD_W-1];
          end
          if ((phase_r == PH_DIV) && div_done) begin
            phase_r <= PH_GO;
            if (state_r == ST_V0) begin
              vx_r    <= vel_post(div_quot, vneg_r);
              state_r <= ST_V1;
            end else if (state_r == ST_V1) begin
              vy_r    <= vel_post(div_quot, vneg_r);
              state_r <= ST_V2;
            end else begin
              vw_r    <= vel_post(div_quot, vneg_r);
              state_r <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          phase_r <= PH_GO;
        end
      endcase
    end
  end

  // result payload: hold until transferred, then take the next one
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_px_r <= pose_x_r;
      o_py_r <= pose_y_r;
      o_hd_r <= head_r;
      o_vx_r <= vx_r;
      o_vy_r <= vy_r;
      o_vw_r <= vw_r;
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_pos_x    = o_px_r;
  assign out_pos_y    = o_py_r;
  assign out_heading  = o_hd_r;
  assign out_vel_x    = o_vx_r;
  assign out_vel_y    = o_vy_r;
  assign out_yaw_rate = o_vw_r;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the mecanum wheel odometry block.
`timescale 1ns / 100ps

module tb;
  import mwo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
  localparam int PHASE_ITEMS = 210;
  localparam int PHASES = 5;

  typedef struct {
    logic              link_ok;
    logic signed [31:0] count_one;
    logic signed [31:0] count_two;
    logic signed [31:0] count_three;
    logic signed [31:0] count_four;
    logic [31:0]       elapsed_us;
  } reading_t;

  typedef struct {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [31:0] heading;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic signed [63:0] yaw_rate;
  } pose_t;

  class odometry_scoreboard;
    localparam logic signed [127:0] W_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] W_MIN = -W_MAX - 128'sd1;
    localparam logic signed [63:0] PI_Q29 = 64'sd1686629713;
    localparam logic signed [63:0] TWO_PI_Q29 = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q29 = 64'sd843314857;
    localparam logic signed [63:0] GAIN_K = 64'sd652032874;

    logic [47:0]        dist_per_count;
    logic [31:0]        yaw_gain;
    logic [63:0]        last_counts[4];
    logic signed [63:0] pose_x;
    logic signed [63:0] pose_y;
    logic signed [31:0] heading;
    pose_t              expected_poses[$];
    int                 errors;
    logic signed [63:0] atan_q30[32];

    function new();
      atan_q30 = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                   64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                   64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                   64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                   64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                   64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
                   64'h00000001, 64'h00000000};
      dist_per_count = DPC_RST;
      yaw_gain = YG_RST;
      for (int i = 0; i < 4; i++) last_counts[i] = '0;
      pose_x = '0;
      pose_y = '0;
      heading = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DPC) dist_per_count = data;
      else if (idx == CFG_YG) yaw_gain = data[31:0];
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction

    function logic signed [127:0] widen(logic signed [63:0] v);
      return v;
    endfunction

    function logic signed [63:0] clamp(logic signed [127:0] v);
      if (v > W_MAX) return W_MAX[63:0];
      if (v < W_MIN) return W_MIN[63:0];
      return v[63:0];
    endfunction

    function logic signed [63:0] round_shift(logic signed [127:0] w, int sh);
      logic signed [127:0] r;
      r = (w + (128'sd1 <<< (sh - 1))) >>> sh;
      return clamp(r);
    endfunction

    // step * 1e6 / us, truncated toward zero
    function logic signed [63:0] per_second(logic signed [63:0] v, logic [31:0] us);
      logic signed [127:0] p;
      logic [127:0]        mag;
      logic [127:0]        q;
      p = widen(v) * 128'sd1000000;
      mag = (p < 0) ? -p : p;
      q = mag / {96'b0, us};
      if (p >= 0) return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? W_MAX[63:0] : q[63:0];
      if (q > 128'h8000_0000_0000_0000) return W_MIN[63:0];
      return -q[63:0];
    endfunction

    function void rotate_terms(logic signed [31:0] ang, output logic signed [63:0] c,
                               output logic signed [63:0] s);
      logic signed [63:0] h, x, y, z, xs, ys;
      logic               flip;
      h = ang;
      x = GAIN_K;
      y = '0;
      flip = 1'b0;
      if (h > HALF_PI_Q29) begin
        h = h - PI_Q29;
        flip = 1'b1;
      end else if (h < -HALF_PI_Q29) begin
        h = h + PI_Q29;
        flip = 1'b1;
      end
      z = h * 2;
      for (int i = 0; i < ((ANGLE_STEPS > 32) ? 32 : ANGLE_STEPS); i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - atan_q30[i];
        end else begin
          x = x + ys; y = y - xs; z = z + atan_q30[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_reading(reading_t rd);
      logic [63:0]        mask;
      logic [63:0]        cur[4];
      logic [63:0]        df;
      logic signed [63:0] d[4];
      logic signed [63:0] sx, sy, st, dx, dy, dist_t, dth, dth29, c, s, m, acc, dpc, yg;
      logic signed [127:0] tw;
      pose_t              e;
      if (!rd.link_ok) return;
      mask = (64'd1 << COUNT_BITS) - 64'd1;
      // wheel order: minus two, minus three, four, one
      cur[0] = (64'd0 - 64'(rd.count_two)) & mask;
      cur[1] = (64'd0 - 64'(rd.count_three)) & mask;
      cur[2] = 64'(rd.count_four) & mask;
      cur[3] = 64'(rd.count_one) & mask;
      for (int i = 0; i < 4; i++) begin
        df = (cur[i] - last_counts[i]) & mask;
        d[i] = $signed(df << (64 - COUNT_BITS)) >>> (64 - COUNT_BITS);
        last_counts[i] = cur[i];
      end
      sx = d[0] + d[1] + d[2] + d[3];
      sy = -d[0] + d[1] - d[2] + d[3];
      st = -d[0] - d[1] + d[2] + d[3];
      dpc = $signed({16'b0, dist_per_count});
      yg = $signed({32'b0, yaw_gain});
      dx = round_shift(widen(sx) * widen(dpc), 18);
      dy = round_shift(widen(sy) * widen(dpc), 18);
      dist_t = round_shift(widen(st) * widen(dpc), 16);
      tw = widen(dist_t) * widen(yg);
      dth = round_shift(tw, 30);
      dth29 = round_shift(tw, 33);
      rotate_terms(heading, c, s);
      pose_x = clamp(widen(pose_x) +
                     widen(round_shift(widen(dx) * widen(c) - widen(dy) * widen(s), 30)));
      pose_y = clamp(widen(pose_y) +
                     widen(round_shift(widen(dx) * widen(s) + widen(dy) * widen(c), 30)));
      m = dth29 % TWO_PI_Q29;
      if (m < 0) m = m + TWO_PI_Q29;
      acc = 64'(heading) + PI_Q29 + m;
      if (acc >= TWO_PI_Q29) acc = acc - TWO_PI_Q29;
      heading = 32'(acc - PI_Q29);
      e.pos_x = pose_x;
      e.pos_y = pose_y;
      e.heading = heading;
      e.vel_x = (rd.elapsed_us != 0) ? per_second(dx, rd.elapsed_us) : '0;
      e.vel_y = (rd.elapsed_us != 0) ? per_second(dy, rd.elapsed_us) : '0;
      e.yaw_rate = (rd.elapsed_us != 0) ? per_second(dth, rd.elapsed_us) : '0;
      expected_poses.push_back(e);
    endfunction

    function void compare(string field, logic signed [63:0] exp_v, logic signed [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, field, exp_v, act_v);
      end
    endfunction

    function void check_pose(pose_t act);
      pose_t e;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual pos_x %0d", $realtime, act.pos_x);
        return;
      end
      e = expected_poses.pop_front();
      compare("pos_x", e.pos_x, act.pos_x);
      compare("pos_y", e.pos_y, act.pos_y);
      compare("heading", 64'(e.heading), 64'(act.heading));
      compare("vel_x", e.vel_x, act.vel_x);
      compare("vel_y", e.vel_y, act.vel_y);
      compare("yaw_rate", e.yaw_rate, act.yaw_rate);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_link_ok;
  logic signed [31:0]    in_count_one, in_count_two, in_count_three, in_count_four;
  logic [31:0]           in_elapsed_us;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [63:0]    out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_yaw_rate;
  logic signed [31:0]    out_heading;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  odometry_scoreboard sb = new();
  logic               no_idle;         // final stretch runs without any gaps or stalls
  logic signed [31:0] sent_counts[4];  // last valid counts, so random walks stay plausible

  mecanum_wheel_odometry_top i_dut (.*);

  // 20 ns clock: 10 high, 10 low
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_pose('{out_pos_x, out_pos_y, out_heading, out_vel_x, out_vel_y, out_yaw_rate});
    end
  end

  // Receiver: ready comes and goes in random bursts; hold it high at the end.
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (no_idle || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Drive one reading and wait for its transfer; note it only once accepted.
  task automatic send_reading(reading_t rd);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_link_ok     <= rd.link_ok;
    in_count_one   <= rd.count_one;
    in_count_two   <= rd.count_two;
    in_count_three <= rd.count_three;
    in_count_four  <= rd.count_four;
    in_elapsed_us  <= rd.elapsed_us;
    do @(posedge clk); while (!in_ready);
    sb.note_reading(rd);
    if (rd.link_ok) begin
      sent_counts = '{rd.count_one, rd.count_two, rd.count_three, rd.count_four};
    end
  endtask

  task automatic send_fields(logic ok, logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
                             logic [31:0] c4, logic [31:0] us);
    send_reading('{ok, c1, c2, c3, c4, us});
  endtask

  // Drain all outstanding results, then wait with the input idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Mostly small wheel steps from the last counts; sometimes big jumps or full noise.
  task automatic random_reading(output reading_t rd);
    logic signed [31:0] step;
    int                 kind;
    kind = $urandom_range(0, 19);
    rd.link_ok = ($urandom_range(0, 9) != 0);
    rd.count_one = sent_counts[0];
    rd.count_two = sent_counts[1];
    rd.count_three = sent_counts[2];
    rd.count_four = sent_counts[3];
    for (int i = 0; i < 4; i++) begin
      if (kind < 14) step = $signed($urandom_range(0, 4000)) - 2000;
      else if (kind < 17) step = $signed($urandom_range(0, 2097152)) - 1048576;
      else step = $urandom;
      case (i)
        0: rd.count_one = rd.count_one + step;
        1: rd.count_two = rd.count_two + step;
        2: rd.count_three = rd.count_three + step;
        default: rd.count_four = rd.count_four + step;
      endcase
    end
    case ($urandom_range(0, 9))
      0: rd.elapsed_us = '0;
      1: rd.elapsed_us = $urandom;
      2: rd.elapsed_us = $urandom_range(1, 20);
      default: rd.elapsed_us = $urandom_range(1000, 10000);
    endcase
  endtask

  initial begin
    reading_t rd;
    no_idle = 1'b0;
    sent_counts = '{default: '0};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_link_ok <= 1'b0;
    in_count_one <= '0;
    in_count_two <= '0;
    in_count_three <= '0;
    in_count_four <= '0;
    in_elapsed_us <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DPC;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults first.
    send_fields(1'b1, 0, 0, 0, 0, 1000);
    send_fields(1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hFFFF_FFFF);
    send_fields(1'b1, 100, -100, -100, 100, 5000);            // straight ahead
    send_fields(1'b1, 300, 0, -200, 0, 5000);                 // sideways mix
    send_fields(1'b1, 5000, 2000, 5000, 8000, 2500);          // turn
    send_fields(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_fields(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);  // wrap
    send_fields(1'b1, 32'h8000_0010, 32'h7FFF_FFF0, 32'h8000_0020, 32'h8000_0000, 0);
    send_fields(1'b1, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_fields(1'b1, 32'h4000_0000, 32'h4000_0000, 32'hC000_0000, 32'hC000_0000, 7);
    drain();

    // Directed: register extremes, saturating pose and huge heading steps.
    write_reg(CFG_DPC, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_YG, 48'h0000_FFFF_FFFF);
    write_reg(CFG_SPARE, 48'h1234_5678_9ABC);
    send_fields(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_fields(1'b1, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1000);
    send_fields(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_fields(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 3);
    send_fields(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 3);
    drain();
    write_reg(CFG_DPC, '0);
    write_reg(CFG_YG, '0);
    send_fields(1'b1, 12345, -777, 9, 32'h8000_0000, 100);
    send_fields(1'b1, 0, 0, 0, 0, 0);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_DPC, DPC_RST);
          write_reg(CFG_YG, {16'b0, YG_RST});
        end
        1: begin
          write_reg(CFG_DPC, 48'hFFFF_FFFF_FFFF);
          write_reg(CFG_YG, 48'h0000_FFFF_FFFF);
        end
        2: begin
          write_reg(CFG_DPC, {$urandom, $urandom});
          write_reg(CFG_YG, {16'b0, $urandom});
        end
        3: begin
          write_reg(CFG_DPC, {16'b0, $urandom});
          write_reg(CFG_YG, {16'b0, 32'($urandom_range(0, 1000))});
        end
        default: begin
          write_reg(CFG_DPC, DPC_RST);
          write_reg(CFG_YG, {16'b0, YG_RST});
          no_idle = 1'b1;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once mid-phase until the pipe is empty
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        random_reading(rd);
        send_reading(rd);
      end
      drain();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: generous bound over the slowest legal run.
  initial begin
    #(64'd150_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
